/* hdl/ssbdt_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Sprite blit package
// Shared constants, register indexes and the control/status bundles that run
// between the blit controller and its datapath.
// ---------------------------------------------------------------------------
package ssbdt_pkg;

   localparam int RAY_COUNT_DEF = 180;
   localparam int MAX_SCALE     = 8;
   localparam int SPRITE_SIZE   = 256;
   localparam int SCREEN_SIZE   = 4096;

   localparam int SCALE_W  = 4;
   localparam int DEPTH_W  = 24;
   localparam int ORIGIN_W = 13;
   localparam int VIEW_W   = 13;
   localparam int INDEX_W  = 8;
   localparam int SRC_W    = 8;
   localparam int COLOR_W  = 32;
   localparam int PIX_W    = 12;
   localparam int COORD_W  = 15;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [SCALE_W-1:0] SCALE_RST  = 4'd1;
   localparam logic [VIEW_W-1:0]  VIEW_RST   = 13'd1024;
   localparam logic [VIEW_W-1:0]  SWIDTH_RST = 13'd1024;
   localparam logic [VIEW_W-1:0]  SHEIGHT_RST = 13'd768;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SCALE        = 3'd0,
      CSR_SPRITE_DEPTH = 3'd1,
      CSR_ORIGIN_X     = 3'd2,
      CSR_ORIGIN_Y     = 3'd3,
      CSR_VIEW_WIDTH   = 3'd4,
      CSR_SCREEN_WIDTH = 3'd5,
      CSR_SCREEN_HEIGHT = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic load;
      logic capture;
      logic setup;
      logic bounds;
      logic div_start;
      logic fetch;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic div_done;
      logic depth_hit;
      logic last;
   } status_type;

endpackage
`default_nettype wire

/* hdl/scaled_sprite_blit_depth_test_unit.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Scaled sprite blitter with column depth test
// Loads a per-ray wall depth table and turns each visible source pixel into
// a clipped scale-by-scale square of screen writes.
// ---------------------------------------------------------------------------
//  channel  | direction | carries
//  req_*    | in        | depth load (tuser 0) or source pixel (tuser 1)
//  rsp_*    | out       | one screen pixel write, tlast on the final one
//  csr_*    | in        | control register writes, no read-back
//
//  A depth load is written as it is accepted, and loads may follow each
//  other every cycle while no source pixel is in flight. A source pixel
//  holds the input through setup, bounds and check when it is discarded
//  early, otherwise also through ray division, depth fetch and compare,
//  and through the writes; the ray divider makes one quotient bit per cycle.
//  rsp stalls simply hold the current write; no new item is taken until
//  the last write of the square has transferred. Reset is synchronous and
//  restores the control registers; the depth table is not cleared.
// ---------------------------------------------------------------------------
module scaled_sprite_blit_depth_test_unit #(
   parameter int RAY_COUNT = ssbdt_pkg::RAY_COUNT_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // depth_index, depth_value, src_col, src_row, src_color
   input  wire logic [79:0]                       req_tdata,
   // mode
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // pixel_x, pixel_y, pixel_rgba
   output logic      [55:0]                       rsp_tdata,
   output logic                                   rsp_tlast,
   input  wire logic                              csr_wen,
   input  wire logic [ssbdt_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [ssbdt_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ssbdt_pkg::*;

   cmd_type            cmd;
   status_type         status;
   logic [PIX_W-1:0]   pixel_x;
   logic [PIX_W-1:0]   pixel_y;
   logic [COLOR_W-1:0] pixel_rgba;

   ssbdt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ssbdt_dp #(
      .RAY_COUNT(RAY_COUNT)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .depth_index (req_tdata[7:0]),
      .depth_value (req_tdata[31:8]),
      .src_col     (req_tdata[39:32]),
      .src_row     (req_tdata[47:40]),
      .src_color   (req_tdata[79:48]),
      .cmd         (cmd),
      .status      (status),
      .pixel_x     (pixel_x),
      .pixel_y     (pixel_y),
      .pixel_rgba  (pixel_rgba)
   );

   assign rsp_tdata = {pixel_rgba, pixel_y, pixel_x};
   assign rsp_tlast = status.last;

endmodule
`default_nettype wire

/* hdl/ssbdt_ram.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ---------------------------------------------------------------------------
module ssbdt_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 180,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

/* hdl/ssbdt_div.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Ray index divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module ssbdt_div #(
   parameter int DVD_W = 21,
   parameter int DVS_W = 13
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic      [DVD_W-1:0] quotient,
   output logic                  done
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] dq_ff, dq_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DVS_W:0]   rem_sh;
   logic [DVS_W:0]   diff;
   logic             ge;

   always_comb begin
      rem_sh = {rem_ff, dq_ff[DVD_W-1]};
      diff   = rem_sh - {1'b0, dvs_ff};
      ge     = (rem_sh >= {1'b0, dvs_ff});
      rem_in = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      dq_in  = {dq_ff[DVD_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DVD_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dq_ff  <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         dq_ff  <= dq_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient = dq_ff;
   assign done     = done_ff;

endmodule
`default_nettype wire

/* hdl/ssbdt_dp.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Sprite blit datapath
// Control registers, pixel capture, screen bounds, ray lookup through the
// divider and depth table, and the write-address counters of the square.
// ---------------------------------------------------------------------------
module ssbdt_dp #(
   parameter int RAY_COUNT = ssbdt_pkg::RAY_COUNT_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_wen,
   input  wire logic [ssbdt_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire logic [ssbdt_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire logic [ssbdt_pkg::INDEX_W-1:0]         depth_index,
   input  wire logic [ssbdt_pkg::DEPTH_W-1:0]         depth_value,
   input  wire logic [ssbdt_pkg::SRC_W-1:0]           src_col,
   input  wire logic [ssbdt_pkg::SRC_W-1:0]           src_row,
   input  wire logic [ssbdt_pkg::COLOR_W-1:0]         src_color,
   input  wire ssbdt_pkg::cmd_type                    cmd,
   output ssbdt_pkg::status_type                      status,
   output logic      [ssbdt_pkg::PIX_W-1:0]           pixel_x,
   output logic      [ssbdt_pkg::PIX_W-1:0]           pixel_y,
   output logic      [ssbdt_pkg::COLOR_W-1:0]         pixel_rgba
);
   import ssbdt_pkg::*;

   localparam int RA_W  = $clog2(RAY_COUNT);
   localparam int DVD_W = VIEW_W + RA_W;
   localparam int LIM_W = COORD_W - 1;
   localparam int CS_W  = SRC_W + SCALE_W;
   localparam int CMP_W = 11;
   localparam logic [DVD_W-1:0] RAY_MAX = DVD_W'(RAY_COUNT - 1);

   // control registers
   logic [SCALE_W-1:0]  scale_ff;
   logic [DEPTH_W-1:0]  sdepth_ff;
   logic [ORIGIN_W-1:0] orgx_ff;
   logic [ORIGIN_W-1:0] orgy_ff;
   logic [VIEW_W-1:0]   vw_ff;
   logic [VIEW_W-1:0]   sw_ff;
   logic [VIEW_W-1:0]   sh_ff;

   // per-pixel snapshot
   logic [SRC_W-1:0]    col_ff;
   logic [SRC_W-1:0]    row_ff;
   logic [COLOR_W-1:0]  color_ff;
   logic [SCALE_W-1:0]  s_ff, s_in;
   logic [ORIGIN_W-1:0] ox_ff;
   logic [ORIGIN_W-1:0] oy_ff;
   logic [VIEW_W-1:0]   vws_ff;
   logic [DEPTH_W-1:0]  sd_ff;
   logic [LIM_W-1:0]    limx_ff, limx_in;
   logic [LIM_W-1:0]    limy_ff, limy_in;

   // setup and bounds
   logic [CS_W-1:0]            csx, csy;
   logic signed [COORD_W-1:0]  sx_ff, sx_in;
   logic signed [COORD_W-1:0]  fy_ff, fy_in;
   logic                       pre_skip_ff, pre_skip_in;
   logic signed [COORD_W-1:0]  sxe, fye, limx_s, limy_s;
   logic signed [COORD_W-1:0]  x_hi, y_hi, y_lo, x_lastw, y_lastw;
   logic                       skip_ff, skip_in;
   logic [DVD_W-1:0]           product_ff, product_in;
   logic [PIX_W-1:0]           x_first_ff, x_last_ff, y_last_ff;
   logic [PIX_W-1:0]           cur_x_ff, cur_y_ff;

   // ray lookup
   logic [DVD_W-1:0]   quotient;
   logic               div_done;
   logic [DVD_W-1:0]   ray;
   logic [DEPTH_W-1:0] rdata;
   logic               table_we;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= SCALE_RST;
         sdepth_ff <= '0;
         orgx_ff   <= '0;
         orgy_ff   <= '0;
         vw_ff     <= VIEW_RST;
         sw_ff     <= SWIDTH_RST;
         sh_ff     <= SHEIGHT_RST;
      end else if (csr_wen) begin
         case (csr_index_type'(csr_addr))
            CSR_SCALE:         scale_ff  <= csr_wdata[SCALE_W-1:0];
            CSR_SPRITE_DEPTH:  sdepth_ff <= csr_wdata[DEPTH_W-1:0];
            CSR_ORIGIN_X:      orgx_ff   <= csr_wdata[ORIGIN_W-1:0];
            CSR_ORIGIN_Y:      orgy_ff   <= csr_wdata[ORIGIN_W-1:0];
            CSR_VIEW_WIDTH:    vw_ff     <= csr_wdata[VIEW_W-1:0];
            CSR_SCREEN_WIDTH:  sw_ff     <= csr_wdata[VIEW_W-1:0];
            CSR_SCREEN_HEIGHT: sh_ff     <= csr_wdata[VIEW_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      s_in    = (scale_ff > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : scale_ff;
      limx_in = (LIM_W'(sw_ff) < LIM_W'(SCREEN_SIZE)) ? LIM_W'(sw_ff) : LIM_W'(SCREEN_SIZE);
      limy_in = (LIM_W'(sh_ff) < LIM_W'(SCREEN_SIZE)) ? LIM_W'(sh_ff) : LIM_W'(SCREEN_SIZE);

      // top left corner of the square
      csx   = CS_W'(col_ff) * CS_W'(s_ff);
      csy   = CS_W'(row_ff) * CS_W'(s_ff);
      sx_in = {{(COORD_W - ORIGIN_W){ox_ff[ORIGIN_W-1]}}, ox_ff}
              + {{(COORD_W - CS_W){1'b0}}, csx};
      fy_in = {{(COORD_W - ORIGIN_W){oy_ff[ORIGIN_W-1]}}, oy_ff}
              + {{(COORD_W - CS_W){1'b0}}, csy};
      pre_skip_in = (s_ff == '0) || (CMP_W'(col_ff) >= CMP_W'(SPRITE_SIZE))
                    || (CMP_W'(row_ff) >= CMP_W'(SPRITE_SIZE))
                    || (color_ff[7:0] == 8'd0);

      // clip the square against the screen
      sxe    = sx_ff + COORD_W'(s_ff);
      fye    = fy_ff + COORD_W'(s_ff);
      limx_s = {1'b0, limx_ff};
      limy_s = {1'b0, limy_ff};
      x_hi   = (sxe < limx_s) ? sxe : limx_s;
      y_hi   = (fye < limy_s) ? fye : limy_s;
      y_lo   = fy_ff[COORD_W-1] ? '0 : fy_ff;
      x_lastw = x_hi - COORD_W'(1);
      y_lastw = y_hi - COORD_W'(1);
      skip_in = pre_skip_ff || sx_ff[COORD_W-1] || (sx_ff >= x_hi) || (y_lo >= y_hi);
      product_in = DVD_W'(sx_ff[VIEW_W-1:0]) * DVD_W'(RAY_COUNT);

      ray = ((vws_ff == '0) || (quotient > RAY_MAX)) ? RAY_MAX : quotient;
      table_we = cmd.load && (CMP_W'(depth_index) < CMP_W'(RAY_COUNT));
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         col_ff   <= src_col;
         row_ff   <= src_row;
         color_ff <= src_color;
         s_ff     <= s_in;
         ox_ff    <= orgx_ff;
         oy_ff    <= orgy_ff;
         vws_ff   <= vw_ff;
         sd_ff    <= sdepth_ff;
         limx_ff  <= limx_in;
         limy_ff  <= limy_in;
      end
      if (cmd.setup) begin
         sx_ff       <= sx_in;
         fy_ff       <= fy_in;
         pre_skip_ff <= pre_skip_in;
      end
      if (cmd.bounds) begin
         skip_ff    <= skip_in;
         product_ff <= product_in;
         x_first_ff <= sx_ff[PIX_W-1:0];
         x_last_ff  <= x_lastw[PIX_W-1:0];
         y_last_ff  <= y_lastw[PIX_W-1:0];
         cur_x_ff   <= sx_ff[PIX_W-1:0];
         cur_y_ff   <= y_lo[PIX_W-1:0];
      end else if (cmd.advance) begin
         // row by row: wrap x at the right edge of the clipped square
         if (cur_x_ff == x_last_ff) begin
            cur_x_ff <= x_first_ff;
            cur_y_ff <= cur_y_ff + 1'b1;
         end else begin
            cur_x_ff <= cur_x_ff + 1'b1;
         end
      end
   end

   ssbdt_div #(
      .DVD_W(DVD_W),
      .DVS_W(VIEW_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (product_ff),
      .divisor  (vws_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   ssbdt_ram #(
      .WIDTH(DEPTH_W),
      .DEPTH(RAY_COUNT),
      .ADDR_W(RA_W)
   ) u_depth_ram (
      .clock (clock),
      .we    (table_we),
      .waddr (RA_W'(depth_index)),
      .wdata (depth_value),
      .re    (cmd.fetch),
      .raddr (ray[RA_W-1:0]),
      .rdata (rdata)
   );

   always_comb begin
      status.skip      = skip_ff;
      status.div_done  = div_done;
      status.depth_hit = (rdata > sd_ff);
      status.last      = (cur_x_ff == x_last_ff) && (cur_y_ff == y_last_ff);
   end

   assign pixel_x    = cur_x_ff;
   assign pixel_y    = cur_y_ff;
   assign pixel_rgba = color_ff;

endmodule
`default_nettype wire

/* hdl/ssbdt_ctrl.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Sprite blit controller
// Sequences one source pixel through setup, clipping, ray division, depth
// fetch and the write burst; owns both channel handshakes.
// ---------------------------------------------------------------------------
module ssbdt_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_mode,
   output logic                       req_tready,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire ssbdt_pkg::status_type status,
   output ssbdt_pkg::cmd_type         cmd
);
   import ssbdt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_BOUNDS,
      ST_CHECK,
      ST_DIVIDE,
      ST_FETCH,
      ST_COMPARE,
      ST_EMIT
   } state_type;

   state_type state_ff;
   logic      ready_ff;
   logic      valid_ff;
   logic      accept;

   assign accept = req_tvalid && ready_ff;

   always_comb begin
      cmd           = '0;
      cmd.load      = accept && !req_mode;
      cmd.capture   = accept && req_mode;
      cmd.setup     = (state_ff == ST_SETUP);
      cmd.bounds    = (state_ff == ST_BOUNDS);
      cmd.div_start = (state_ff == ST_CHECK) && !status.skip;
      cmd.fetch     = (state_ff == ST_FETCH);
      cmd.advance   = (state_ff == ST_EMIT) && valid_ff && rsp_tready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept && req_mode) begin
                  ready_ff <= 1'b0;
                  state_ff <= ST_SETUP;
               end
            end
            ST_SETUP: begin
               state_ff <= ST_BOUNDS;
            end
            ST_BOUNDS: begin
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               if (status.skip) begin
                  ready_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               if (status.div_done) begin
                  state_ff <= ST_FETCH;
               end
            end
            ST_FETCH: begin
               state_ff <= ST_COMPARE;
            end
            ST_COMPARE: begin
               if (status.depth_hit) begin
                  valid_ff <= 1'b1;
                  state_ff <= ST_EMIT;
               end else begin
                  ready_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            ST_EMIT: begin
               // drop valid after the closing transfer of the square
               if (rsp_tready && status.last) begin
                  valid_ff <= 1'b0;
                  ready_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b1;
               valid_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_tready = ready_ff;
   assign rsp_tvalid = valid_ff;

endmodule
`default_nettype wire

/* hdl/ssbdt_checker.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Sprite blit port checker
// Watches the top-level ports for handshake and sequencing slips.
// ---------------------------------------------------------------------------
module ssbdt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [55:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   // a stalled write holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp payload changed under stall");

   // no new item is taken while a square is being written
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("req ready during write burst");

   // the closing write ends the burst
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid && req_tready)
      else $error("burst continued after tlast");

   // a depth load leaves the block ready, a pixel makes it busy
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> (req_tready == !$past(req_tuser)))
      else $error("wrong ready after input transfer");

endmodule

bind scaled_sprite_blit_depth_test_unit ssbdt_checker u_ssbdt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

/* sim/blit_checker.sv */
// ---------------------------------------------------------------------------
// Sprite blit checker
// Watches the control port and both stream channels of the blitter. It keeps
// its own copy of the ray depth table and of the control registers, expands
// every accepted source pixel into the expected pixel writes, and compares
// each transferred write against the oldest one still expected.
// ---------------------------------------------------------------------------
module blit_checker #(
   parameter logic MODE_DRAW = 1'b1
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [79:0] req_tdata,
   input  wire logic        req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [55:0] rsp_tdata,
   input  wire logic        rsp_tlast,
   input  wire logic        csr_wen,
   input  wire logic [ssbdt_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [ssbdt_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int               errors,
   output int               pending
);
   import ssbdt_pkg::*;

   typedef struct packed {
      logic [11:0] x;
      logic [11:0] y;
      logic [31:0] rgba;
      logic        last;
   } pixel_write_t;

   pixel_write_t expected_writes[$];

   logic [23:0]        ray_depth [RAY_COUNT_DEF];
   logic [3:0]         scale_r;
   logic [23:0]        sprite_depth_r;
   logic signed [12:0] origin_x_r;
   logic signed [12:0] origin_y_r;
   logic [12:0]        view_width_r;
   logic [12:0]        screen_width_r;
   logic [12:0]        screen_height_r;

   initial begin
      errors  = 0;
      pending = 0;
      for (int i = 0; i < RAY_COUNT_DEF; i++) ray_depth[i] = '0;
   end

   // Expand one source pixel into its clipped square of writes, y outer.
   task automatic predict_square(input logic [7:0] col, input logic [7:0] row,
                                 input logic [31:0] color);
      int s, sx, ray, lim_x, lim_y, fx, fy;
      bit have_prev;
      pixel_write_t prev;
      s = (scale_r > MAX_SCALE) ? MAX_SCALE : int'(scale_r);
      have_prev = 0;
      prev = '0;
      if (s == 0 || color[7:0] == 8'd0) return;
      sx = int'(origin_x_r) + int'(col) * s;
      if (sx < 0) return;
      if (view_width_r == '0)
         ray = RAY_COUNT_DEF - 1;
      else
         ray = (sx * RAY_COUNT_DEF) / int'(view_width_r);
      if (ray > RAY_COUNT_DEF - 1) ray = RAY_COUNT_DEF - 1;
      if (!(ray_depth[ray] > sprite_depth_r)) return;
      lim_x = (int'(screen_width_r) < SCREEN_SIZE) ? int'(screen_width_r) : SCREEN_SIZE;
      lim_y = (int'(screen_height_r) < SCREEN_SIZE) ? int'(screen_height_r) : SCREEN_SIZE;
      for (int dy = 0; dy < s; dy++) begin
         fy = int'(origin_y_r) + int'(row) * s + dy;
         if (fy >= 0 && fy < lim_y) begin
            for (int dx = 0; dx < s; dx++) begin
               fx = sx + dx;
               if (fx >= 0 && fx < lim_x) begin
                  // hold each write back one step so the final one can be marked
                  if (have_prev) expected_writes.push_back(prev);
                  prev.x    = fx[11:0];
                  prev.y    = fy[11:0];
                  prev.rgba = color;
                  prev.last = 1'b0;
                  have_prev = 1;
               end
            end
         end
      end
      if (have_prev) begin
         prev.last = 1'b1;
         expected_writes.push_back(prev);
      end
   endtask

   task automatic check_write();
      pixel_write_t want;
      if (expected_writes.size() == 0) begin
         $error("pixel write (%0d,%0d) with no write expected",
                rsp_tdata[11:0], rsp_tdata[23:12]);
         errors++;
         return;
      end
      want = expected_writes.pop_front();
      if (rsp_tdata[11:0] !== want.x) begin
         $error("pixel_x: expected %0d, actual %0d", want.x, rsp_tdata[11:0]);
         errors++;
      end
      if (rsp_tdata[23:12] !== want.y) begin
         $error("pixel_y: expected %0d, actual %0d", want.y, rsp_tdata[23:12]);
         errors++;
      end
      if (rsp_tdata[55:24] !== want.rgba) begin
         $error("pixel_rgba: expected %h, actual %h", want.rgba, rsp_tdata[55:24]);
         errors++;
      end
      if (rsp_tlast !== want.last) begin
         $error("last_of_run: expected %0d, actual %0d", want.last, rsp_tlast);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         scale_r         <= SCALE_RST;
         sprite_depth_r  <= '0;
         origin_x_r      <= '0;
         origin_y_r      <= '0;
         view_width_r    <= VIEW_RST;
         screen_width_r  <= SWIDTH_RST;
         screen_height_r <= SHEIGHT_RST;
         expected_writes.delete();
      end else begin
         // drain first: a write on this edge belongs to an older pixel
         if (rsp_tvalid && rsp_tready) check_write();
         if (csr_wen) begin
            case (csr_addr)
               CSR_SCALE:         scale_r         <= csr_wdata[3:0];
               CSR_SPRITE_DEPTH:  sprite_depth_r  <= csr_wdata[23:0];
               CSR_ORIGIN_X:      origin_x_r      <= csr_wdata[12:0];
               CSR_ORIGIN_Y:      origin_y_r      <= csr_wdata[12:0];
               CSR_VIEW_WIDTH:    view_width_r    <= csr_wdata[12:0];
               CSR_SCREEN_WIDTH:  screen_width_r  <= csr_wdata[12:0];
               CSR_SCREEN_HEIGHT: screen_height_r <= csr_wdata[12:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == MODE_DRAW)
               predict_square(req_tdata[39:32], req_tdata[47:40], req_tdata[79:48]);
            else if (req_tdata[7:0] < RAY_COUNT_DEF)
               ray_depth[req_tdata[7:0]] = req_tdata[31:8];
         end
      end
      pending = expected_writes.size();
   end

endmodule

/* sim/tb.sv */
// ---------------------------------------------------------------------------
// Sprite blitter testbench
// Fills the ray depth table, runs directed pixels through the clipping,
// occlusion and register corner cases, then random loads and pixels under
// several random register settings with random stalls on both channels.
// ---------------------------------------------------------------------------
module tb;
   import ssbdt_pkg::*;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_DRAW = 1'b1;
   localparam int   IDLE_LIMIT = 5000;
   localparam int   DRAIN_CYCLES = 64;
   localparam int   LONG_HOLD = 400;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;    // depth_index, depth_value, src_col, src_row, src_color
   logic        req_tuser;    // mode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;    // pixel_x, pixel_y, pixel_rgba
   logic        rsp_tlast;
   logic        csr_wen;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int  errors;
   int  pending;
   int  hold_requests = 0;
   int  holds_served = 0;
   int  idle_cycles = 0;
   bit  quiet = 0;

   scaled_sprite_blit_depth_test_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   blit_checker #(.MODE_DRAW(MODE_DRAW)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .errors     (errors),
      .pending    (pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Offer one item and hold it until it transfers; valid stays high after.
   task automatic send_item(input logic mode, input logic [7:0] index,
                            input logic [23:0] value, input logic [7:0] col,
                            input logic [7:0] row, input logic [31:0] color);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = mode;
      req_tdata  = {color, row, col, value, index};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_load(input logic [7:0] index, input logic [23:0] value);
      send_item(MODE_LOAD, index, value, 8'($urandom), 8'($urandom), $urandom);
   endtask

   task automatic send_draw(input logic [7:0] col, input logic [7:0] row,
                            input logic [31:0] color);
      send_item(MODE_DRAW, 8'($urandom), 24'($urandom), col, row, color);
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // Let a pixel that makes no writes finish before registers change.
   task automatic settle();
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [23:0] val);
      @(negedge clock);
      csr_wen   = 1'b1;
      csr_addr  = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_wen   = 1'b0;
   endtask

   task automatic randomize_config();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         csr_write(CSR_SCALE, 24'($urandom_range(9, 15)));
      else if (pick == 1)
         csr_write(CSR_SCALE, 24'(MAX_SCALE));
      else
         csr_write(CSR_SCALE, 24'($urandom_range(1, 4)));
      csr_write(CSR_SPRITE_DEPTH, 24'($urandom_range(0, 24'h7FFFFF)));
      csr_write(CSR_ORIGIN_X, 24'(13'(int'($urandom_range(0, 160)) - 80)));
      csr_write(CSR_ORIGIN_Y, 24'(13'(int'($urandom_range(0, 160)) - 80)));
      if ($urandom_range(0, 9) == 0)
         csr_write(CSR_VIEW_WIDTH, 24'd0);
      else
         csr_write(CSR_VIEW_WIDTH, 24'($urandom_range(64, 4096)));
      csr_write(CSR_SCREEN_WIDTH, 24'($urandom_range(32, 4096)));
      csr_write(CSR_SCREEN_HEIGHT, 24'($urandom_range(32, 4096)));
   endtask

   task automatic run_random(input int count);
      logic [7:0]  col, row;
      logic [31:0] color;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 3) == 0) begin
            send_load(8'($urandom_range(0, 255)), 24'($urandom));
         end else begin
            // mostly small coordinates so the squares land on screen
            if ($urandom_range(0, 3) != 0) begin
               col = 8'($urandom_range(0, 63));
               row = 8'($urandom_range(0, 63));
            end else begin
               col = 8'($urandom);
               row = 8'($urandom);
            end
            color = $urandom;
            if ($urandom_range(0, 7) == 0) color[7:0] = 8'h00;
            send_draw(col, row, color);
         end
      end
   endtask

   // Receiver: random stall bursts, plus one long hold-off on request.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served < hold_requests) begin
            holds_served++;
            rsp_tready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 9) - 1) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // Watchdog: end the run if no transfer of any kind happens for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = MODE_LOAD;
      req_tdata  = '0;
      csr_wen    = 1'b0;
      csr_addr   = CSR_SCALE;
      csr_wdata  = '0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Load every ray so no draw can read an unwritten entry.
      for (int i = 0; i < RAY_COUNT_DEF; i++) begin
         if (i == 0 || i == 89 || i == RAY_COUNT_DEF - 1)
            send_load(8'(i), 24'hFFFFFF);
         else if (i % 16 == 5)
            send_load(8'(i), 24'h000000);
         else
            send_load(8'(i), 24'($urandom));
      end

      // Register reset values: corners of the sprite, zero alpha, bad indexes.
      send_draw(8'd0, 8'd0, 32'hFFFFFFFF);
      send_draw(8'd255, 8'd255, 32'h89ABCD01);
      send_draw(8'd7, 8'd9, 32'hFFFFFF00);
      send_load(8'd180, 24'h123456);
      send_load(8'd255, 24'hFFFFFF);
      send_load(8'd0, 24'h000000);
      send_draw(8'd0, 8'd0, 32'h000000FF);
      send_load(8'd0, 24'hFFFFFF);

      // Largest scale, negative origin, zero view width.
      settle();
      csr_write(CSR_SCALE, 24'(MAX_SCALE));
      csr_write(CSR_SPRITE_DEPTH, 24'h000100);
      csr_write(CSR_ORIGIN_X, 24'(13'(-20)));
      csr_write(CSR_ORIGIN_Y, 24'(13'(-3)));
      csr_write(CSR_VIEW_WIDTH, 24'd0);
      csr_write(CSR_SCREEN_WIDTH, 24'(SCREEN_SIZE));
      csr_write(CSR_SCREEN_HEIGHT, 24'(SCREEN_SIZE));
      send_draw(8'd0, 8'd0, 32'h11223344);
      send_draw(8'd2, 8'd0, 32'h55667788);
      send_draw(8'd3, 8'd0, 32'h99AABBCC);
      send_draw(8'd255, 8'd255, 32'hDDEEFF01);

      // Scale above the maximum, origin at the far corner, all-ones widths.
      settle();
      csr_write(CSR_SCALE, 24'd15);
      csr_write(CSR_SPRITE_DEPTH, 24'd0);
      csr_write(CSR_ORIGIN_X, 24'd4095);
      csr_write(CSR_ORIGIN_Y, 24'd4095);
      csr_write(CSR_VIEW_WIDTH, 24'd8191);
      csr_write(CSR_SCREEN_WIDTH, 24'd8191);
      csr_write(CSR_SCREEN_HEIGHT, 24'd8191);
      send_draw(8'd0, 8'd0, 32'hCAFE0080);
      send_draw(8'd1, 8'd0, 32'hCAFE0081);

      // Zero scale draws nothing.
      settle();
      csr_write(CSR_SCALE, 24'd0);
      send_draw(8'd5, 8'd5, 32'h000000FF);

      // Wall depth equal to the sprite depth hides the pixel.
      settle();
      csr_write(CSR_SCALE, 24'd1);
      csr_write(CSR_SPRITE_DEPTH, 24'hFFFFFF);
      send_draw(8'd0, 8'd0, 32'h000000FF);

      // One-pixel screen and view: ray clamp and full clipping.
      settle();
      csr_write(CSR_SPRITE_DEPTH, 24'd0);
      csr_write(CSR_ORIGIN_X, 24'd0);
      csr_write(CSR_ORIGIN_Y, 24'd0);
      csr_write(CSR_VIEW_WIDTH, 24'd1);
      csr_write(CSR_SCREEN_WIDTH, 24'd1);
      csr_write(CSR_SCREEN_HEIGHT, 24'd1);
      send_draw(8'd0, 8'd0, 32'h7F7F7F7F);
      send_draw(8'd1, 8'd0, 32'h7F7F7F7F);

      for (int phase = 0; phase < 4; phase++) begin
         settle();
         randomize_config();
         if (phase == 1) hold_requests++;
         if (phase == 3) quiet = 1;
         if (phase == 2) begin
            run_random(20);
            wait_drained();
            run_random(20);
         end else begin
            run_random(40);
         end
      end

      settle();
      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
